/* rtl/interval_set_insert_merge_core_macros.svh */
// assertion macros for the interval set core
`ifndef INTERVAL_SET_INSERT_MERGE_CORE_MACROS_SVH
`define INTERVAL_SET_INSERT_MERGE_CORE_MACROS_SVH

// same-cycle implication
`define ISIM_CHECK(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ISIM_CHECK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/isim_pkg.sv */
// constants and types for the interval set core
`default_nettype none
package isim_pkg;
	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int AW       = 64;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_READ   = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	localparam logic [2:0] ST_EMPTY    = 3'd0;
	localparam logic [2:0] ST_INSERTED = 3'd1;
	localparam logic [2:0] ST_COVERED  = 3'd2;
	localparam logic [2:0] ST_MERGED   = 3'd3;
	localparam logic [2:0] ST_OVERFLOW = 3'd4;
	localparam logic [2:0] ST_READ_OK  = 3'd5;
	localparam logic [2:0] ST_READ_BAD = 3'd6;
	localparam logic [2:0] ST_CLEARED  = 3'd7;

	typedef struct packed {
		logic [AW-1:0] lo;
		logic [AW-1:0] hi;
	} entry_t;

	typedef enum logic [12:0] {
		S_IDLE      = 13'b0000000000001,
		S_SCAN_RD   = 13'b0000000000010,
		S_SCAN_CHK  = 13'b0000000000100,
		S_SHIFT_RD  = 13'b0000000001000,
		S_SHIFT_WR  = 13'b0000000010000,
		S_MERGE_RD  = 13'b0000000100000,
		S_MERGE_CHK = 13'b0000001000000,
		S_MERGE_WR  = 13'b0000010000000,
		S_PACK_RD   = 13'b0000100000000,
		S_PACK_WR   = 13'b0001000000000,
		S_READ_RD   = 13'b0010000000000,
		S_READ_CHK  = 13'b0100000000000,
		S_DONE      = 13'b1000000000000
	} state_t;
endpackage
`default_nettype wire

/* rtl/interval_set_insert_merge_core.sv */
// Sorted interval set with insert and merge over one entry memory that has one
// read port and one write port. Insert takes each entry scanned, shifted, merged or
// compacted through a read state and then a check or write state.
// Read uses a read and a check state; clear and empty inserts go straight to the result beat.
// One item at a time; in_stall stays high until the result beat is taken.
// Reset (arst_n low, asynchronous) empties the set; entry contents are not cleared.
`default_nettype none
`include "interval_set_insert_merge_core_macros.svh"
module interval_set_insert_merge_core import isim_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [1:0]    kind,
	input  wire logic [AW-1:0] start_addr,
	input  wire logic [AW-1:0] end_addr,
	input  wire logic [5:0]    read_index,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [2:0]         status,
	output logic [6:0]         entry_count,
	output logic [AW-1:0]      entry_begin,
	output logic [AW-1:0]      entry_end
);
	entry_t mem [CAPACITY];
	entry_t rd_q;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   pos_q;
	logic [CNT_W-1:0]   ptr_q;
	logic [CNT_W-1:0]   dst_q;
	logic [AW-1:0]      lo_q;
	logic [AW-1:0]      hi_q;
	logic               out_valid_q;
	logic [2:0]         status_q;
	logic [AW-1:0]      ebeg_q;
	logic [AW-1:0]      eend_q;

	logic               we;
	logic [ADDR_W-1:0]  wa;
	logic [ADDR_W-1:0]  ra;
	entry_t             wd;
	logic [CNT_W-1:0]   ptr_dec;

	assign ptr_dec = ptr_q - CNT_W'(1);

	always_comb begin
		we = 1'b0;
		wa = pos_q[ADDR_W-1:0];
		wd = '{lo: lo_q, hi: hi_q};
		ra = pos_q[ADDR_W-1:0];
		case (state_q)
			S_SHIFT_RD: begin
				ra = ptr_dec[ADDR_W-1:0];
				we = (ptr_q == pos_q);
			end
			S_SHIFT_WR: begin
				we = 1'b1;
				wa = ptr_q[ADDR_W-1:0];
				wd = rd_q;
			end
			S_MERGE_RD: ra = ptr_q[ADDR_W-1:0];
			S_MERGE_WR: we = 1'b1;
			S_PACK_RD:  ra = ptr_q[ADDR_W-1:0];
			S_PACK_WR: begin
				we = 1'b1;
				wa = dst_q[ADDR_W-1:0];
				wd = rd_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			pos_q       <= '0;
			ptr_q       <= '0;
			dst_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						ebeg_q <= '0;
						eend_q <= '0;
						lo_q   <= start_addr;
						hi_q   <= end_addr;
						pos_q  <= (kind == KIND_READ) ? CNT_W'(read_index) : '0;
						case (kind)
							KIND_INSERT: begin
								if (start_addr >= end_addr) begin
									status_q    <= ST_EMPTY;
									out_valid_q <= 1'b1;
									state_q     <= S_DONE;
								end else begin
									state_q <= S_SCAN_RD;
								end
							end
							KIND_READ: begin
								if (CNT_W'(read_index) < count_q) begin
									state_q <= S_READ_RD;
								end else begin
									status_q    <= ST_READ_BAD;
									out_valid_q <= 1'b1;
									state_q     <= S_DONE;
								end
							end
							KIND_CLEAR: begin
								count_q     <= '0;
								status_q    <= ST_CLEARED;
								out_valid_q <= 1'b1;
								state_q     <= S_DONE;
							end
							default: begin
								status_q    <= ST_EMPTY;
								out_valid_q <= 1'b1;
								state_q     <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN_RD: begin
					if (pos_q == count_q) begin
						if (count_q >= CNT_W'(CAPACITY)) begin
							status_q    <= ST_OVERFLOW;
							out_valid_q <= 1'b1;
							state_q     <= S_DONE;
						end else begin
							ptr_q   <= count_q;
							state_q <= S_SHIFT_RD;
						end
					end else begin
						state_q <= S_SCAN_CHK;
					end
				end
				S_SCAN_CHK: begin
					if (rd_q.hi < lo_q) begin
						pos_q   <= pos_q + CNT_W'(1);
						state_q <= S_SCAN_RD;
					end else if (hi_q < rd_q.lo) begin
						if (count_q >= CNT_W'(CAPACITY)) begin
							status_q    <= ST_OVERFLOW;
							out_valid_q <= 1'b1;
							state_q     <= S_DONE;
						end else begin
							ptr_q   <= count_q;
							state_q <= S_SHIFT_RD;
						end
					end else if (rd_q.lo <= lo_q && hi_q <= rd_q.hi) begin
						status_q    <= ST_COVERED;
						out_valid_q <= 1'b1;
						state_q     <= S_DONE;
					end else begin
						if (rd_q.lo < lo_q) lo_q <= rd_q.lo;
						if (rd_q.hi > hi_q) hi_q <= rd_q.hi;
						ptr_q   <= pos_q + CNT_W'(1);
						state_q <= S_MERGE_RD;
					end
				end
				S_SHIFT_RD: begin
					if (ptr_q == pos_q) begin
						count_q     <= count_q + CNT_W'(1);
						status_q    <= ST_INSERTED;
						out_valid_q <= 1'b1;
						state_q     <= S_DONE;
					end else begin
						state_q <= S_SHIFT_WR;
					end
				end
				S_SHIFT_WR: begin
					ptr_q   <= ptr_dec;
					state_q <= S_SHIFT_RD;
				end
				S_MERGE_RD: begin
					if (ptr_q == count_q) state_q <= S_MERGE_WR;
					else state_q <= S_MERGE_CHK;
				end
				S_MERGE_CHK: begin
					if (rd_q.lo <= hi_q) begin
						if (rd_q.hi > hi_q) hi_q <= rd_q.hi;
						ptr_q   <= ptr_q + CNT_W'(1);
						state_q <= S_MERGE_RD;
					end else begin
						state_q <= S_MERGE_WR;
					end
				end
				S_MERGE_WR: begin
					dst_q   <= pos_q + CNT_W'(1);
					state_q <= S_PACK_RD;
				end
				S_PACK_RD: begin
					if (ptr_q == count_q) begin
						count_q     <= dst_q;
						status_q    <= ST_MERGED;
						out_valid_q <= 1'b1;
						state_q     <= S_DONE;
					end else begin
						state_q <= S_PACK_WR;
					end
				end
				S_PACK_WR: begin
					ptr_q   <= ptr_q + CNT_W'(1);
					dst_q   <= dst_q + CNT_W'(1);
					state_q <= S_PACK_RD;
				end
				S_READ_RD: state_q <= S_READ_CHK;
				S_READ_CHK: begin
					ebeg_q      <= rd_q.lo;
					eend_q      <= rd_q.hi;
					status_q    <= ST_READ_OK;
					out_valid_q <= 1'b1;
					state_q     <= S_DONE;
				end
				S_DONE: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_count = 7'(count_q);
	assign entry_begin = ebeg_q;
	assign entry_end   = eend_q;

	// sanity checks
	`ISIM_CHECK(a_count_cap, 1'b1, count_q <= CNT_W'(CAPACITY), "entry count above capacity")
	`ISIM_CHECK(a_idle_no_beat, state_q == S_IDLE, !out_valid_q, "result beat pending while idle")
	`ISIM_CHECK(a_zero_fields, out_valid_q && status_q != ST_READ_OK, ebeg_q == '0 && eend_q == '0, "entry fields not zero")
	`ISIM_CHECK_NEXT(a_busy_after_accept, in_valid && !in_stall, state_q != S_IDLE, "idle right after accept")
endmodule
`default_nettype wire
